// ===== hw/rtl/lsbx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsbx_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_SAMPLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_ENABLE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_RANGE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCATTER_SPAN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_COMPONENTS = 3'd4;

    localparam int CFG_DATA_W = 32;
    localparam int WORD_W     = 32;
    localparam int ACC_W      = 15;
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;

    // Result status codes
    localparam logic [1:0] STATUS_BYTE  = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_END   = 2'd2;

    // Input kinds
    localparam logic KIND_COMPONENT = 1'b0;
    localparam logic KIND_ALIGN     = 1'b1;

    // Divider: 2*WORD_W by WORD_W, quotient known to fit WORD_W bits
    localparam int DIV_STEPS = WORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lsbx_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle.
// The upper half of the dividend must be below the divisor.
module lsbx_div
    import lsbx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire div_ctl_t              ctl,
    input  wire logic [2*WORD_W-1:0]   dividend,
    input  wire logic [WORD_W-1:0]     divisor,
    output div_stat_t                  stat,
    output logic [WORD_W-1:0]          quotient
);

    logic [WORD_W-1:0]    rem_reg;
    logic [WORD_W-1:0]    quo_reg;
    logic [WORD_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      diff;
    logic                 take;

    assign trial = {rem_reg, quo_reg[WORD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign take  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                rem_reg  <= dividend[2*WORD_W-1:WORD_W];
                quo_reg  <= dividend[WORD_W-1:0];
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // shift one dividend bit in, subtract where it fits
                rem_reg <= take ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
                quo_reg <= {quo_reg[WORD_W-2:0], take};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lsb_stego_bit_extractor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Handshake              Payload
// s_axis     in   tvalid/tready          tdata: component_value; tuser: kind
// m_axis     out  tvalid/tready          tdata: byte_value; tuser: status
// cfg        in   cfg_we (no wait)       cfg_index, cfg_data
//
// One request at a time: s_axis_tready is high only while the sequencer idles.
// Align: IDLE only. Halted, skipped or out-of-range component: CHECK.
// Sample without scatter: CHECK, SAMPLE; scatter sample: CHECK, then MUL and
// DWAIT twice, then SAMPLE, making two passes through the shared 64/32 radix-2
// divider (32 steps each). A result waits in EMIT while the output register is full.
// rst_n clears all state asynchronously; a taken result frees the output.
module lsb_stego_bit_extractor_unit
    import lsbx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] component_value
    input  wire logic                  s_axis_tuser,   // [0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [7:0] byte_value
    output logic [1:0]                 m_axis_tuser,   // [1:0] status
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DWAIT,
        ST_SAMPLE,
        ST_EMIT
    } state_t;

    // Configuration registers
    logic [CNT_W-1:0]  bps_reg;
    logic              scat_en_reg;
    logic [WORD_W-1:0] range_reg;
    logic [WORD_W-1:0] span_reg;
    logic [WORD_W-1:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg     <= CNT_W'(1);
            scat_en_reg <= 1'b0;
            range_reg   <= WORD_W'(1);
            span_reg    <= '0;
            total_reg   <= WORD_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BITS_PER_SAMPLE:  bps_reg     <= cfg_data[CNT_W-1:0];
                CFG_SCATTER_ENABLE:   scat_en_reg <= cfg_data[0];
                CFG_SCATTER_RANGE:    range_reg   <= cfg_data[WORD_W-1:0];
                CFG_SCATTER_SPAN:     span_reg    <= cfg_data[WORD_W-1:0];
                CFG_TOTAL_COMPONENTS: total_reg   <= cfg_data[WORD_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer and datapath state
    state_t             state_reg;
    logic [BYTE_W-1:0]  comp_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [WORD_W-1:0]  skip_reg;
    logic [WORD_W-1:0]  pos_reg;
    logic [WORD_W-1:0]  idx_reg;
    logic               halted_reg;
    logic [WORD_W-1:0]  p_reg;       // scatter position of this sample
    logic               hi_phase_reg; // first division uses p, second p-1
    logic [WORD_W-1:0]  q1_reg;
    logic [WORD_W-1:0]  stride_reg;
    logic [BYTE_W-1:0]  pend_byte_reg;
    logic [1:0]         pend_status_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [1:0]         out_status_reg;

    // Shared multiplier feeding the divider; p-1 is the stored position
    logic [WORD_W-1:0]   mul_op;
    logic [2*WORD_W-1:0] product;
    div_ctl_t            div_ctl;
    div_stat_t           div_stat;
    logic [WORD_W-1:0]   div_quo;

    assign mul_op        = hi_phase_reg ? p_reg : pos_reg;
    assign product       = mul_op * span_reg;
    assign div_ctl.start = (state_reg == ST_MUL);

    lsbx_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (product),
        .divisor  (range_reg),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // Position check and stride
    logic [WORD_W:0]   p_next;
    logic [WORD_W-1:0] stride_diff;
    logic [WORD_W:0]   reach;

    assign p_next      = {1'b0, pos_reg} + 1'b1;
    assign stride_diff = q1_reg - div_quo;
    assign reach       = {1'b0, idx_reg} + {1'b0, stride_reg};

    // Bit packing: clamp the sample width to 1..8
    logic [CNT_W-1:0]  nbits;
    logic [BYTE_W-1:0] keep_mask;
    logic [ACC_W-1:0]  acc_sum;
    logic [CNT_W-1:0]  cnt_sum;

    always_comb
    begin
        if (bps_reg == '0)
            nbits = CNT_W'(1);
        else if (bps_reg > CNT_W'(BYTE_W))
            nbits = CNT_W'(BYTE_W);
        else
            nbits = bps_reg;
    end

    assign keep_mask = ~(8'hFF << nbits);
    assign acc_sum   = acc_reg | (ACC_W'(comp_reg & keep_mask) << cnt_reg);
    assign cnt_sum   = cnt_reg + nbits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            comp_reg        <= '0;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            skip_reg        <= '0;
            pos_reg         <= '0;
            idx_reg         <= '0;
            halted_reg      <= 1'b0;
            p_reg           <= '0;
            hi_phase_reg    <= 1'b0;
            q1_reg          <= '0;
            stride_reg      <= '0;
            pend_byte_reg   <= '0;
            pend_status_reg <= STATUS_BYTE;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_status_reg  <= STATUS_BYTE;
        end
        else
        begin
            // drop the result once the sink takes it; in EMIT the next one
            // replaces it instead
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EMIT))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        comp_reg <= s_axis_tdata;
                        if (s_axis_tuser == KIND_ALIGN)
                        begin
                            // drop pending bits, even when halted
                            acc_reg <= '0;
                            cnt_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_CHECK;
                        end
                    end
                end

                ST_CHECK:
                begin
                    if (halted_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (idx_reg >= total_reg)
                    begin
                        halted_reg      <= 1'b1;
                        pend_byte_reg   <= '0;
                        pend_status_reg <= STATUS_END;
                        state_reg       <= ST_EMIT;
                    end
                    else if (skip_reg != '0)
                    begin
                        skip_reg  <= skip_reg - 1'b1;
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else if (scat_en_reg)
                    begin
                        if (p_next > {1'b0, range_reg})
                        begin
                            halted_reg      <= 1'b1;
                            pend_byte_reg   <= '0;
                            pend_status_reg <= STATUS_RANGE;
                            state_reg       <= ST_EMIT;
                        end
                        else
                        begin
                            p_reg        <= p_next[WORD_W-1:0];
                            hi_phase_reg <= 1'b1;
                            state_reg    <= ST_MUL;
                        end
                    end
                    else
                    begin
                        stride_reg <= WORD_W'(1);
                        state_reg  <= ST_SAMPLE;
                    end
                end

                ST_MUL:
                begin
                    // divider latches the product on this edge
                    state_reg <= ST_DWAIT;
                end

                ST_DWAIT:
                begin
                    if (div_stat.done)
                    begin
                        if (hi_phase_reg)
                        begin
                            q1_reg       <= div_quo;
                            hi_phase_reg <= 1'b0;
                            state_reg    <= ST_MUL;
                        end
                        else
                        begin
                            // a zero stride counts as one
                            stride_reg <= (stride_diff == '0) ? WORD_W'(1) : stride_diff;
                            state_reg  <= ST_SAMPLE;
                        end
                    end
                end

                ST_SAMPLE:
                begin
                    if (scat_en_reg)
                        pos_reg <= p_reg;
                    if (reach >= {1'b0, total_reg})
                    begin
                        halted_reg      <= 1'b1;
                        pend_byte_reg   <= '0;
                        pend_status_reg <= STATUS_END;
                        state_reg       <= ST_EMIT;
                    end
                    else
                    begin
                        skip_reg <= stride_reg - 1'b1;
                        idx_reg  <= idx_reg + 1'b1;
                        if (cnt_sum >= CNT_W'(BYTE_W))
                        begin
                            pend_byte_reg   <= acc_sum[BYTE_W-1:0];
                            pend_status_reg <= STATUS_BYTE;
                            acc_reg         <= acc_sum >> BYTE_W;
                            cnt_reg         <= cnt_sum - CNT_W'(BYTE_W);
                            state_reg       <= ST_EMIT;
                        end
                        else
                        begin
                            acc_reg   <= acc_sum;
                            cnt_reg   <= cnt_sum;
                            state_reg <= ST_IDLE;
                        end
                    end
                end

                ST_EMIT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_byte_reg   <= pend_byte_reg;
                        out_status_reg <= pend_status_reg;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STATUS_BYTE)) |-> halted_reg)
        else $error("error status shown while not halted");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DWAIT))
        else $error("divider finished outside its wait state");

    a_div_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == ST_DWAIT))
        else $error("divider running outside its wait state");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg < CNT_W'(BYTE_W)))
        else $error("a full byte left pending in idle");
`endif

endmodule

`default_nettype wire

// ===== verif/lsbx_byte_check.sv =====
`timescale 1ns / 1ps

// Watch both streams and the register port, predict every extracted byte or
// error status, and compare each returned result against the oldest one.
module lsbx_byte_check
    import lsbx_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] component_value
    input  wire logic                  s_axis_tuser,   // [0] kind
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [7:0]            m_axis_tdata,   // [7:0] byte_value
    input  wire logic [1:0]            m_axis_tuser,   // [1:0] status
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic [7:0] byte_value;
        logic [1:0] status;
    } extracted_t;

    extracted_t expected_bytes[$];
    int errors = 0;

    // Register copy
    logic [3:0]  bits_per_sample;
    logic        scatter_on;
    logic [31:0] spread_range;
    logic [31:0] spread_span;
    logic [31:0] image_size;

    // Extraction state
    logic [14:0] acc_bits;
    logic [3:0]  acc_count;
    logic [31:0] skip_left;
    logic [31:0] spread_pos;
    logic [31:0] comp_idx;
    logic        stopped;

    function automatic extracted_t make_result(input logic [7:0] value,
                                               input logic [1:0] code);
        extracted_t r;
        r.byte_value = value;
        r.status     = code;
        return r;
    endfunction

    // Append one predicted result behind the ones still outstanding.
    task automatic queue_result(input logic [7:0] value, input logic [1:0] code);
        expected_bytes.insert(expected_bytes.size(), make_result(value, code));
    endtask

    // Advance the extraction state by one request; queue any result it yields.
    task automatic extract_step(input logic kind, input logic [7:0] comp);
        logic [63:0] pos_next;
        logic [63:0] stride;
        logic [3:0]  nbits;
        logic [7:0]  mask;
        logic [14:0] taken;

        if (kind == KIND_ALIGN) begin
            acc_bits  = '0;
            acc_count = '0;
            return;
        end
        if (stopped)
            return;
        if (comp_idx >= image_size) begin
            stopped = 1'b1;
            queue_result(8'h00, STATUS_END);
            return;
        end
        if (skip_left != 0) begin
            skip_left = skip_left - 1;
            comp_idx  = comp_idx + 1;
            return;
        end

        stride = 64'd1;
        if (scatter_on) begin
            pos_next = {32'd0, spread_pos} + 64'd1;
            if (pos_next > {32'd0, spread_range}) begin
                stopped = 1'b1;
                queue_result(8'h00, STATUS_RANGE);
                return;
            end
            stride = (pos_next * {32'd0, spread_span}) / {32'd0, spread_range}
                   - ((pos_next - 64'd1) * {32'd0, spread_span}) / {32'd0, spread_range};
            if (stride == 0)
                stride = 64'd1;
            spread_pos = pos_next[31:0];
        end

        if ({32'd0, comp_idx} + stride >= {32'd0, image_size}) begin
            stopped = 1'b1;
            queue_result(8'h00, STATUS_END);
            return;
        end

        // Clamp the sample width to 1..8
        if (bits_per_sample == 0)
            nbits = 4'd1;
        else if (bits_per_sample > 4'd8)
            nbits = 4'd8;
        else
            nbits = bits_per_sample;

        mask      = 8'hFF >> (4'd8 - nbits);
        taken     = {7'd0, comp & mask};
        acc_bits  = acc_bits | (taken << acc_count);
        acc_count = acc_count + nbits;
        skip_left = 32'(stride - 64'd1);
        comp_idx  = comp_idx + 1;

        if (acc_count >= 4'd8) begin
            queue_result(acc_bits[7:0], STATUS_BYTE);
            acc_bits  = acc_bits >> 8;
            acc_count = acc_count - 4'd8;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        extracted_t got;
        extracted_t want;

        if (!rst_n) begin
            bits_per_sample = 4'd1;
            scatter_on      = 1'b0;
            spread_range    = 32'd1;
            spread_span     = 32'd0;
            image_size      = 32'd1;
            acc_bits        = '0;
            acc_count       = '0;
            skip_left       = '0;
            spread_pos      = '0;
            comp_idx        = '0;
            stopped         = 1'b0;
            expected_bytes.delete();
            pending    <= 0;
            fail_count <= errors;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_BITS_PER_SAMPLE:  bits_per_sample = cfg_data[3:0];
                    CFG_SCATTER_ENABLE:   scatter_on      = cfg_data[0];
                    CFG_SCATTER_RANGE:    spread_range    = cfg_data;
                    CFG_SCATTER_SPAN:     spread_span     = cfg_data;
                    CFG_TOTAL_COMPONENTS: image_size      = cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                extract_step(s_axis_tuser, s_axis_tdata);

            if (m_axis_tvalid && m_axis_tready) begin
                got.byte_value = m_axis_tdata;
                got.status     = m_axis_tuser;
                if (expected_bytes.size() == 0) begin
                    $error("result with none expected: byte_value %02h, status %0d",
                           got.byte_value, got.status);
                    errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.byte_value !== want.byte_value) begin
                        $error("byte_value: expected %02h, actual %02h",
                               want.byte_value, got.byte_value);
                        errors++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, got.status);
                        errors++;
                    end
                end
            end

            pending    <= expected_bytes.size();
            fail_count <= errors;
        end
    end

endmodule

// ===== verif/tb_lsb_stego_bit_extractor_unit.sv =====
`timescale 1ns / 1ps

module tb_lsb_stego_bit_extractor_unit;
    import lsbx_pkg::*;

    localparam int RANDOM_REQUESTS = 1000;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the block
    localparam int SETTLE_CYCLES   = 120;   // covers a scatter sample with no result
    localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no request or result taken

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;   // [7:0] component_value
    logic                  s_axis_tuser;   // [0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [7:0]            m_axis_tdata;   // [7:0] byte_value
    logic [1:0]            m_axis_tuser;   // [1:0] status
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;

    // Sender bookkeeping
    int burst_left      = 0;
    int requests_sent   = 0;
    int components_sent = 0;   // equals the block's component index until it halts
    int quiet_cycles    = 0;

    // Receiver control: set by the stimulus, cleared by the receiver when done
    logic hold_off_req = 1'b0;

    lsb_stego_bit_extractor_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lsbx_byte_check byte_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort when neither a request nor a result has moved for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: stall in a random mode, picked anew when the current one runs out; on request,
    // hold off for a long stretch so the block backs up into its input.
    initial
    begin
        int stall_mode;
        int stall_mode_left;
        int stall_tick;

        stall_mode      = 0;
        stall_mode_left = 0;
        stall_tick      = 0;
        m_axis_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            if (stall_mode_left == 0)
            begin
                stall_mode      = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(16, 200);
            end
            stall_mode_left--;
            stall_tick++;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 7) == 0);
                default: m_axis_tready <= (stall_tick % 3) != 0;
            endcase
        end
    end

    // Offer one request and hold it until taken. Open a new burst, after a
    // random gap, whenever the current burst has run out.
    task automatic send_request(input logic kind, input logic [7:0] value);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        requests_sent++;
        if (kind == KIND_COMPONENT)
            components_sent++;
    endtask

    // Stop offering, wait out every expected result, then let the block finish
    // any request that yields nothing.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all five registers back to back; call only while idle.
    task automatic load_settings(input logic [3:0]  bps,
                                 input logic        scatter_on,
                                 input logic [31:0] spread_range,
                                 input logic [31:0] spread_span,
                                 input logic [31:0] image_size);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BITS_PER_SAMPLE;
        cfg_data  <= {28'd0, bps};
        @(posedge clk);
        cfg_index <= CFG_SCATTER_ENABLE;
        cfg_data  <= {31'd0, scatter_on};
        @(posedge clk);
        cfg_index <= CFG_SCATTER_RANGE;
        cfg_data  <= spread_range;
        @(posedge clk);
        cfg_index <= CFG_SCATTER_SPAN;
        cfg_data  <= spread_span;
        @(posedge clk);
        cfg_index <= CFG_TOTAL_COMPONENTS;
        cfg_data  <= image_size;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Random settings that keep the block running: the scatter range stays far
    // above any position reachable in this run, the image stays huge, and the
    // span keeps strides at a few components.
    task automatic pick_settings();
        logic [3:0]  bps;
        logic        scatter_on;
        logic [31:0] spread_range;
        logic [31:0] spread_span;
        logic [31:0] image_size;
        logic [63:0] span_wide;

        if ($urandom_range(0, 4) == 0)
            bps = 4'($urandom_range(0, 15));   // out-of-range widths get clamped
        else
            bps = 4'($urandom_range(1, 8));
        scatter_on = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0:
            begin
                // uneven strides of one to four
                spread_range = $urandom_range(32'h0001_0000, 32'h3FFF_FFFF);
                span_wide    = 64'(spread_range) * 64'($urandom_range(1, 3))
                             + 64'($urandom % spread_range);
                spread_span  = span_wide[31:0];
            end
            1:
            begin
                // span below range: mix of zero strides and strides of one
                spread_range = $urandom | 32'h0001_0000;
                spread_span  = $urandom % spread_range;
            end
            2:
            begin
                // exact strides
                spread_range = $urandom_range(32'h0001_0000, 32'h0010_0000);
                spread_span  = spread_range * $urandom_range(1, 4);
            end
            default:
            begin
                spread_range = 32'hFFFF_FFFF;
                spread_span  = $urandom;
            end
        endcase
        image_size = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        load_settings(bps, scatter_on, spread_range, spread_span, image_size);
    endtask

    task automatic random_requests(input int count);
        repeat (count)
        begin
            if ($urandom_range(0, 11) == 0)
                send_request(KIND_ALIGN, 8'($urandom));
            else
                send_request(KIND_COMPONENT, 8'($urandom));
        end
    endtask

    initial
    begin
        int phase_no;
        int random_start;
        int end_kind;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = KIND_COMPONENT;
        cfg_we        = 1'b0;
        cfg_index     = CFG_BITS_PER_SAMPLE;
        cfg_data      = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full bytes straight through, an align between whole bytes.
        load_settings(4'd8, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'h00);
        send_request(KIND_COMPONENT, 8'hFF);
        send_request(KIND_COMPONENT, 8'hA5);
        send_request(KIND_ALIGN, 8'hFF);
        send_request(KIND_COMPONENT, 8'h5A);

        // Three bits per sample; the align drops six pending bits.
        wait_idle();
        load_settings(4'd3, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'h05);
        send_request(KIND_COMPONENT, 8'hFA);
        send_request(KIND_ALIGN, 8'h00);
        send_request(KIND_COMPONENT, 8'h07);
        send_request(KIND_COMPONENT, 8'h00);
        send_request(KIND_COMPONENT, 8'hFE);

        // Width zero reads as one, width fifteen as eight.
        wait_idle();
        load_settings(4'd0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'h01);
        send_request(KIND_COMPONENT, 8'h00);
        send_request(KIND_COMPONENT, 8'hFF);
        send_request(KIND_COMPONENT, 8'hFE);
        wait_idle();
        load_settings(4'd15, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'hC3);

        // Scatter with zero span: every stride computes to zero, taken as one.
        wait_idle();
        load_settings(4'd8, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'h81);
        send_request(KIND_COMPONENT, 8'h7E);
        send_request(KIND_COMPONENT, 8'hFF);

        // Scatter with span equal to range at full width: stride of exactly one.
        wait_idle();
        load_settings(4'd8, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(KIND_COMPONENT, 8'h00);
        send_request(KIND_COMPONENT, 8'hFF);
        send_request(KIND_COMPONENT, 8'h3C);

        // Random phases, each under fresh settings written while idle.
        random_start = requests_sent;
        phase_no     = 0;
        while (requests_sent - random_start < RANDOM_REQUESTS)
        begin
            wait_idle();
            if (phase_no == 2)
            begin
                // Every component yields a byte; stall the receiver meanwhile.
                load_settings(4'd8, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
                hold_off_req = 1'b1;
                repeat (40) send_request(KIND_COMPONENT, 8'($urandom));
            end
            else
            begin
                pick_settings();
                random_requests($urandom_range(20, 80));
            end
            phase_no++;
        end

        // Drive the block into its sticky error, one kind per run, then
        // confirm that components are dropped and aligns are harmless.
        wait_idle();
        end_kind = $urandom_range(0, 2);
        case (end_kind)
            0:
                // range of one is already used up by the earlier scatter samples
                load_settings(4'($urandom_range(1, 8)), 1'b1, 32'd1, $urandom, 32'hFFFF_FFFF);
            1:
                // image ends a few components ahead
                load_settings(4'($urandom_range(1, 8)), 1'b0, 32'hFFFF_FFFF, 32'h0000_0000,
                              32'(components_sent + $urandom_range(2, 20)));
            default:
                // image shrunk below the current index
                load_settings(4'($urandom_range(1, 8)), 1'b0, 32'hFFFF_FFFF, 32'h0000_0000,
                              32'd1);
        endcase
        repeat (40)
        begin
            if ($urandom_range(0, 3) == 0)
                send_request(KIND_ALIGN, 8'($urandom));
            else
                send_request(KIND_COMPONENT, 8'($urandom));
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== lsb_stego_bit_extractor_unit.f =====
hw/rtl/lsbx_pkg.sv
hw/rtl/lsbx_div.sv
hw/rtl/lsb_stego_bit_extractor_unit.sv
verif/lsbx_byte_check.sv
verif/tb_lsb_stego_bit_extractor_unit.sv
